/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; the including scope must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CCP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ccp_pkg.sv */
// Types and codes for the constant pool parser.
// No dependencies; used by every module of the block.
package ccp_pkg;

	localparam int unsigned OutTdataW = 120;

	// constant pool tags
	localparam logic [7:0] TAG_UTF8     = 8'd1;
	localparam logic [7:0] TAG_INT      = 8'd3;
	localparam logic [7:0] TAG_FLOAT    = 8'd4;
	localparam logic [7:0] TAG_LONG     = 8'd5;
	localparam logic [7:0] TAG_DOUBLE   = 8'd6;
	localparam logic [7:0] TAG_CLASS    = 8'd7;
	localparam logic [7:0] TAG_STRING   = 8'd8;
	localparam logic [7:0] TAG_NAMETYPE = 8'd12;
	localparam logic [7:0] TAG_UNSUP_LO = 8'd15;
	localparam logic [7:0] TAG_UNSUP_HI = 8'd20;

	// record kinds
	localparam logic [3:0] KIND_UTF8_HDR  = 4'd0;
	localparam logic [3:0] KIND_UTF8_BYTE = 4'd1;
	localparam logic [3:0] KIND_BAD_TAG   = 4'd12;
	localparam logic [3:0] KIND_UNSUP     = 4'd13;

	typedef enum logic [5:0] {
		PH_TAG   = 6'b000001,
		PH_ULEN  = 6'b000010,
		PH_UBODY = 6'b000100,
		PH_VALUE = 6'b001000,
		PH_IDX1  = 6'b010000,
		PH_IDX2  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic        pool_done;
		logic        entry_end;
		logic [15:0] slot_number;
		logic [15:0] second_ref;
		logic [15:0] first_ref;
		logic [63:0] value_bits;
		logic [3:0]  record_kind;
	} rec_t;

endpackage

/* rtl/ccp_parse.sv */
// Parser state and per-byte decode for the constant pool parser.
// Depends on ccp_pkg.
module ccp_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [15:0]   cfg_wr_data,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          restart,
	output logic          rec_valid,
	output ccp_pkg::rec_t rec
);
	import ccp_pkg::*;

	logic [15:0] pool_count_q;
	phase_t      phase_q, n_phase;
	logic [4:0]  tag_q, n_tag;
	logic [15:0] bl_q, n_bl;
	logic [63:0] vs_q, n_vs;
	logic [15:0] hfi_q, n_hfi;
	logic [15:0] slots_q, n_slots;
	logic [15:0] cur_q, n_cur;
	logic        halt_q, n_halt;

	logic        fin;
	logic [1:0]  used;
	logic [15:0] shift16, bl_dec;
	logic [63:0] shift64;
	logic [7:0]  b;

	assign b = data_byte;

	always_comb begin
		n_phase = phase_q;
		n_tag   = tag_q;
		n_bl    = bl_q;
		n_vs    = vs_q;
		n_hfi   = hfi_q;
		n_slots = slots_q;
		n_cur   = cur_q;
		n_halt  = halt_q;
		rec       = '0;
		rec_valid = 1'b0;
		fin       = 1'b0;
		used      = 2'd1;

		if (restart) begin
			n_halt  = 1'b0;
			n_slots = (pool_count_q != 16'd0) ? pool_count_q - 16'd1 : 16'd0;
			n_cur   = 16'd1;
			n_phase = PH_TAG;
			n_bl    = '0;
			n_vs    = '0;
			n_hfi   = '0;
		end

		rec.slot_number = n_cur;
		shift16 = {n_vs[7:0], b};
		shift64 = {n_vs[55:0], b};
		bl_dec  = n_bl - 16'd1;

		if (!n_halt && n_slots != 16'd0) begin
			unique case (n_phase)
				PH_TAG: begin
					n_tag = b[4:0];
					n_vs  = '0;
					priority if (b == TAG_UTF8) begin
						n_phase = PH_ULEN;
						n_bl    = 16'd2;
					end else if (b == TAG_INT || b == TAG_FLOAT) begin
						n_phase = PH_VALUE;
						n_bl    = 16'd4;
					end else if (b == TAG_LONG || b == TAG_DOUBLE) begin
						n_phase = PH_VALUE;
						n_bl    = 16'd8;
					end else if (b >= TAG_CLASS && b <= TAG_NAMETYPE) begin
						n_phase = PH_IDX1;
						n_bl    = 16'd2;
					end else begin
						// bad or unsupported tag: report and halt
						n_tag           = '0;
						n_halt          = 1'b1;
						rec_valid       = 1'b1;
						rec.record_kind = (b >= TAG_UNSUP_LO && b <= TAG_UNSUP_HI)
							? KIND_UNSUP : KIND_BAD_TAG;
						rec.value_bits  = {56'd0, b};
						rec.entry_end   = 1'b1;
					end
				end
				PH_ULEN: begin
					n_vs = {48'd0, shift16};
					n_bl = bl_dec;
					if (bl_dec == 16'd0) begin
						rec_valid       = 1'b1;
						rec.record_kind = KIND_UTF8_HDR;
						if (shift16 == 16'd0) begin
							fin           = 1'b1;
							rec.entry_end = 1'b1;
						end else begin
							rec.value_bits = {48'd0, shift16};
							n_phase        = PH_UBODY;
							n_bl           = shift16;
							n_vs           = '0;
						end
					end
				end
				PH_UBODY: begin
					n_bl            = bl_dec;
					rec_valid       = 1'b1;
					rec.record_kind = KIND_UTF8_BYTE;
					rec.value_bits  = {56'd0, b};
					if (bl_dec == 16'd0) begin
						fin           = 1'b1;
						rec.entry_end = 1'b1;
					end
				end
				PH_VALUE: begin
					n_vs = shift64;
					n_bl = bl_dec;
					if (bl_dec == 16'd0) begin
						rec_valid       = 1'b1;
						rec.record_kind = 4'(n_tag - 5'd1);
						rec.value_bits  = shift64;
						rec.entry_end   = 1'b1;
						fin             = 1'b1;
						// long and double take two slots
						if (n_tag == TAG_LONG[4:0] || n_tag == TAG_DOUBLE[4:0])
							used = 2'd2;
					end
				end
				PH_IDX1: begin
					n_vs = {48'd0, shift16};
					n_bl = bl_dec;
					if (bl_dec == 16'd0) begin
						if (n_tag == TAG_CLASS[4:0] || n_tag == TAG_STRING[4:0]) begin
							rec_valid       = 1'b1;
							rec.record_kind = 4'(n_tag - 5'd1);
							rec.first_ref   = shift16;
							rec.entry_end   = 1'b1;
							fin             = 1'b1;
						end else begin
							n_hfi   = shift16;
							n_vs    = '0;
							n_bl    = 16'd2;
							n_phase = PH_IDX2;
						end
					end
				end
				PH_IDX2: begin
					n_vs = {48'd0, shift16};
					n_bl = bl_dec;
					if (bl_dec == 16'd0) begin
						rec_valid       = 1'b1;
						rec.record_kind = 4'(n_tag - 5'd1);
						rec.first_ref   = n_hfi;
						rec.second_ref  = shift16;
						rec.entry_end   = 1'b1;
						fin             = 1'b1;
					end
				end
				default: n_phase = PH_TAG;
			endcase
		end

		if (fin) begin
			// slot count saturates when a two-slot entry lands in the last slot
			n_slots = (n_slots > {14'd0, used}) ? n_slots - {14'd0, used} : 16'd0;
			n_cur   = n_cur + {14'd0, used};
			n_phase = PH_TAG;
			n_bl    = '0;
			n_vs    = '0;
			rec.pool_done = (n_slots == 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_count_q <= 16'd1;
			phase_q      <= PH_TAG;
			tag_q        <= '0;
			bl_q         <= '0;
			vs_q         <= '0;
			hfi_q        <= '0;
			slots_q      <= '0;
			cur_q        <= 16'd1;
			halt_q       <= 1'b0;
		end else begin
			if (cfg_wr_en)
				pool_count_q <= cfg_wr_data;
			if (accept) begin
				phase_q <= n_phase;
				tag_q   <= n_tag;
				bl_q    <= n_bl;
				vs_q    <= n_vs;
				hfi_q   <= n_hfi;
				slots_q <= n_slots;
				cur_q   <= n_cur;
				halt_q  <= n_halt;
			end
		end
	end

endmodule

/* rtl/ccp_skid.sv */
// Output register with a one-deep skid stage for parser records.
// Depends on ccp_pkg.
module ccp_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ccp_pkg::rec_t push_rec,
	output logic          space,
	output logic          out_valid,
	input  logic          out_ready,
	output ccp_pkg::rec_t out_rec
);
	import ccp_pkg::*;

	rec_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic pop;

	assign pop       = out_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_rec   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// push never coincides with a full skid stage
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop)
			out_q <= skid_valid_q ? skid_q : push_rec;
		else if (push)
			skid_q <= push_rec;
	end

endmodule

/* rtl/class_constant_pool_parser.sv */
// Class-file constant pool parser: one pool byte per beat in, one record per beat out.
// Depends on ccp_pkg, ccp_parse and ccp_skid.
//
// Takes one byte of a class-file constant pool each cycle, with restart in tuser on the
// first byte of a pool, and turns entries into records: utf8 gives a length record and
// one record per string byte, numeric entries give their raw bits, reference entries
// their indices; a bad or unsupported tag gives one error record and the parser ignores
// bytes until the next restart. The record kind travels in m_tuser and pool_done in
// m_tlast. Every byte is decoded in the cycle it is accepted, so the block sustains one
// byte per cycle while s_tready is high. Behind a stalled output the skid stage takes one
// more record; bytes that make no record keep flowing, and s_tready drops only while the
// skid stage is full, rising again the cycle after the waiting record is taken. Records
// are registered in the output stage, or held in the skid stage while the output stalls.
// Write pool_count via cfg_wr_en / cfg_wr_data only while idle; the block does not check.
module class_constant_pool_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data,   // pool_count
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,       // data_byte
	input  logic         s_tuser,       // restart
	output logic         m_tvalid,
	input  logic         m_tready,
	// value_bits[63:0], first_ref[79:64], second_ref[95:80], slot_number[111:96],
	// entry_end[112], zero[119:113]
	output logic [ccp_pkg::OutTdataW-1:0] m_tdata,
	output logic [3:0]   m_tuser,       // record_kind
	output logic         m_tlast        // pool_done
);
	import ccp_pkg::*;

	logic accept;
	logic rec_valid;
	rec_t rec, out_rec;

	assign accept = s_tvalid && s_tready;

	ccp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.accept     (accept),
		.data_byte  (s_tdata),
		.restart    (s_tuser),
		.rec_valid  (rec_valid),
		.rec        (rec)
	);

	ccp_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && rec_valid),
		.push_rec (rec),
		.space    (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_rec  (out_rec)
	);

	assign m_tdata = {7'd0, out_rec.entry_end, out_rec.slot_number, out_rec.second_ref,
		out_rec.first_ref, out_rec.value_bits};
	assign m_tuser = out_rec.record_kind;
	assign m_tlast = out_rec.pool_done;

endmodule

/* rtl/ccp_checker.sv */
// Port-level checks for the constant pool parser, bound to the top level.
// Depends on ccp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ccp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [ccp_pkg::OutTdataW-1:0] m_tdata,
	input logic [3:0]   m_tuser,
	input logic         m_tlast
);
	import ccp_pkg::*;

	logic [OutTdataW+4:0] out_beat;
	logic                 entry_end;
	logic                 is_err;

	assign out_beat  = {m_tlast, m_tuser, m_tdata};
	assign entry_end = m_tdata[112];
	assign is_err    = (m_tuser == KIND_BAD_TAG) || (m_tuser == KIND_UNSUP);

	`CCP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(out_beat), "stalled beat changed")
	`CCP_ASSERT(a_done_ends_entry, m_tvalid && m_tlast |-> entry_end, "pool done without entry end")
	`CCP_ASSERT(a_err_record, m_tvalid && is_err |-> entry_end && !m_tlast, "error record flags wrong")
	`CCP_ASSERT(a_kind_range, m_tvalid |-> m_tuser <= KIND_UNSUP && m_tdata[119:113] == 7'd0, "bad kind")
	`CCP_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_tvalid, "output valid in reset")

endmodule

bind class_constant_pool_parser ccp_checker u_ccp_checker (.*);
